[rtl/assert_macros.svh]
// Assertion macros shared by the scheduler RTL.
// Each macro takes a label, a clock, an active-low reset, two expressions and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/prts_pkg.sv]
// Types and constants of the preemptive remaining-time scheduler.
// No dependencies.
package prts_pkg;

	localparam int ID_W    = 8;
	localparam int TIME_W  = 16;
	localparam int TICK_W  = 32;
	localparam int SUM_W   = 40;
	localparam int OP_W    = 2;
	localparam int ENTRY_W = ID_W + 3 * TIME_W;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic REG_POLICY = 1'b0;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] remaining;
	} prts_entry_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ID_W-1:0]   job_id;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] burst;
	} prts_job_t;

	typedef struct packed {
		logic [TICK_W-1:0] slot_time;
		logic              idle;
		logic [ID_W-1:0]   run_id;
		logic              finished;
		logic [TICK_W-1:0] turnaround;
		logic [TICK_W-1:0] waiting;
		logic [SUM_W-1:0]  turnaround_total;
		logic [SUM_W-1:0]  waiting_total;
		logic              all_done;
	} prts_res_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic scan_start;
		logic scan_step;
		logic calc;
		logic emit;
	} prts_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} prts_sts_t;

endpackage

[rtl/prts_in_if.sv]
// Input channel of the scheduler: one job command per beat.
// Depends on prts_pkg.
interface prts_in_if
	import prts_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ID_W-1:0]   job_id;
	logic [TIME_W-1:0] arrival;
	logic [TIME_W-1:0] burst;

	modport source (output valid, op, job_id, arrival, burst, input ready);
	modport sink (input valid, op, job_id, arrival, burst, output ready);
endinterface

[rtl/prts_out_if.sv]
// Result channel of the scheduler: one tick report per beat.
// Depends on prts_pkg.
interface prts_out_if
	import prts_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] slot_time;
	logic              idle;
	logic [ID_W-1:0]   run_id;
	logic              finished;
	logic [TICK_W-1:0] turnaround;
	logic [TICK_W-1:0] waiting;
	logic [SUM_W-1:0]  turnaround_total;
	logic [SUM_W-1:0]  waiting_total;
	logic              all_done;

	modport source (output valid, slot_time, idle, run_id, finished, turnaround, waiting,
		turnaround_total, waiting_total, all_done, input ready);
	modport sink (input valid, slot_time, idle, run_id, finished, turnaround, waiting,
		turnaround_total, waiting_total, all_done, output ready);
endinterface

[rtl/prts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module prts_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/prts_ctrl.sv]
// Controller state machine of the scheduler: sequences load, clear and tick commands.
// Depends on prts_pkg and assert_macros.svh.
`include "assert_macros.svh"
module prts_ctrl
	import prts_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] in_op,
	output logic            in_ready,
	input  prts_sts_t       sts,
	output prts_cmd_t       cmd
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_CALC = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       in_fire;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (in_op)
						OP_LOAD: cmd.load = 1'b1;
						OP_CLEAR: cmd.clear = 1'b1;
						OP_TICK: begin
							cmd.scan_start = 1'b1;
							state_d        = ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_CALC;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_IMPL(a_emit_free, clk, arst_n, cmd.emit, sts.out_free, "emit with result pending")
	`ASSERT_NEXT(a_tick_scan, clk, arst_n, in_fire && in_op == OP_TICK, state_q == ST_SCAN,
		"tick did not start a scan")
endmodule

[rtl/prts_dp.sv]
// Datapath of the scheduler: job table, scan comparator, time, counts, sums, result register.
// Depends on prts_pkg, prts_ram and assert_macros.svh.
`include "assert_macros.svh"
module prts_dp
	import prts_pkg::*;
#(
	parameter int MAX_JOBS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  prts_cmd_t cmd,
	input  prts_job_t job,
	input  logic      policy,
	output prts_sts_t sts,
	output logic      out_valid,
	input  logic      out_ready,
	output prts_res_t res
);
	localparam int IW  = $clog2(MAX_JOBS);
	localparam int LCW = $clog2(MAX_JOBS + 1);

	logic [LCW-1:0]      loaded_q;
	logic [LCW-1:0]      finished_q;
	logic [MAX_JOBS-1:0] done_q;
	logic [TICK_W-1:0]   now_q;
	logic [SUM_W-1:0]    sum_tat_q;
	logic [SUM_W-1:0]    sum_wt_q;
	logic                out_valid_q;

	logic [LCW-1:0]      rd_idx_q;
	logic                vld_s1;
	logic [IW-1:0]       idx_s1;
	logic                have_best_q;
	logic [IW-1:0]       best_idx_q;
	prts_entry_t         best_q;
	logic [TIME_W-1:0]   rem_dec_q;
	logic                fin_q;
	logic [TICK_W-1:0]   tat_q;
	logic [TICK_W-1:0]   wt_q;
	prts_res_t           res_q;

	prts_entry_t         rd_entry;
	prts_entry_t         wr_entry;
	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	logic                ram_re;
	logic                load_ok;
	logic                elig;
	logic                better;
	logic [TIME_W-1:0]   burst_fix;
	logic [SUM_W-1:0]    sum_tat_d;
	logic [SUM_W-1:0]    sum_wt_d;
	logic [LCW-1:0]      finished_d;

	assign load_ok   = cmd.load && (loaded_q < LCW'(MAX_JOBS));
	assign burst_fix = (job.burst == '0) ? TIME_W'(1) : job.burst;
	assign ram_re    = cmd.scan_step && (rd_idx_q < loaded_q);
	assign ram_we    = load_ok || (cmd.emit && have_best_q);
	assign ram_waddr = load_ok ? loaded_q[IW-1:0] : best_idx_q;

	always_comb begin
		if (load_ok) begin
			wr_entry = '{id: job.job_id, arrival: job.arrival, burst: burst_fix,
				remaining: burst_fix};
		end else begin
			wr_entry           = best_q;
			wr_entry.remaining = rem_dec_q;
		end
	end

	prts_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_JOBS)
	) u_tbl (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_entry),
		.re   (ram_re),
		.raddr(rd_idx_q[IW-1:0]),
		.rdata(rd_entry)
	);

	assign elig = vld_s1 && !done_q[idx_s1] && (now_q >= TICK_W'(rd_entry.arrival));
	assign better = !have_best_q ||
		(policy ? (rd_entry.remaining > best_q.remaining)
			: (rd_entry.remaining < best_q.remaining));

	assign sum_tat_d  = fin_q ? sum_tat_q + SUM_W'(tat_q) : sum_tat_q;
	assign sum_wt_d   = fin_q ? sum_wt_q + SUM_W'(wt_q) : sum_wt_q;
	assign finished_d = fin_q ? finished_q + LCW'(1) : finished_q;

	assign sts.scan_done = (rd_idx_q == loaded_q) && !vld_s1;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign res           = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= '0;
			finished_q  <= '0;
			done_q      <= '0;
			now_q       <= '0;
			sum_tat_q   <= '0;
			sum_wt_q    <= '0;
			out_valid_q <= 1'b0;
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			have_best_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.clear) begin
				loaded_q   <= '0;
				finished_q <= '0;
				done_q     <= '0;
				now_q      <= '0;
				sum_tat_q  <= '0;
				sum_wt_q   <= '0;
			end
			if (load_ok) begin
				done_q[loaded_q[IW-1:0]] <= 1'b0;
				loaded_q                 <= loaded_q + LCW'(1);
			end
			if (cmd.scan_start) begin
				rd_idx_q    <= '0;
				vld_s1      <= 1'b0;
				have_best_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				vld_s1 <= ram_re;
				if (ram_re) begin
					rd_idx_q <= rd_idx_q + LCW'(1);
				end
				if (elig && better) begin
					have_best_q <= 1'b1;
				end
			end
			if (cmd.emit) begin
				now_q      <= now_q + TICK_W'(1);
				sum_tat_q  <= sum_tat_d;
				sum_wt_q   <= sum_wt_d;
				finished_q <= finished_d;
				if (fin_q) begin
					done_q[best_idx_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			idx_s1 <= rd_idx_q[IW-1:0];
			if (elig && better) begin
				best_idx_q <= idx_s1;
				best_q     <= rd_entry;
			end
		end
		if (cmd.calc) begin
			rem_dec_q <= best_q.remaining - TIME_W'(1);
			fin_q     <= have_best_q && (best_q.remaining == TIME_W'(1));
			tat_q     <= now_q + TICK_W'(1) - TICK_W'(best_q.arrival);
			wt_q      <= now_q + TICK_W'(1) - TICK_W'(best_q.arrival) - TICK_W'(best_q.burst);
		end
		if (cmd.emit) begin
			res_q.slot_time        <= now_q;
			res_q.idle             <= !have_best_q;
			res_q.run_id           <= have_best_q ? best_q.id : '0;
			res_q.finished         <= fin_q;
			res_q.turnaround       <= fin_q ? tat_q : '0;
			res_q.waiting          <= fin_q ? wt_q : '0;
			res_q.turnaround_total <= sum_tat_d;
			res_q.waiting_total    <= sum_wt_d;
			res_q.all_done         <= (finished_d == loaded_q);
		end
	end

	`ASSERT_IMPL(a_fin_le_loaded, clk, arst_n, 1'b1, finished_q <= loaded_q,
		"more jobs finished than loaded")
	`ASSERT_NEXT(a_emit_valid, clk, arst_n, cmd.emit, out_valid_q,
		"emitted result not presented")
endmodule

[rtl/preemptive_remaining_time_scheduler.sv]
// Preemptive remaining-time scheduler, top level: channels, APB policy register, control, datapath.
// Load and clear beats are handled in the idle state, which the controller does not leave for them.
// A tick beat runs a table scan that reads one entry a cycle, a calc state and an emit state that
// waits for a free result register; the result is registered on emit, and only then is the next beat taken.
// arst_n clears time, counts, sums, done flags and policy_mode; the job table is not reset.
// Depends on prts_pkg, prts_in_if, prts_out_if, prts_ctrl, prts_dp and prts_ram.
module preemptive_remaining_time_scheduler
	import prts_pkg::*;
#(
	parameter int MAX_JOBS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	prts_in_if.sink            in_ch,
	prts_out_if.source         out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);
	logic      policy_q;
	prts_cmd_t cmd;
	prts_sts_t sts;
	prts_job_t job;
	prts_res_t res;
	logic      out_valid;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_POLICY) ? PDATA_W'(policy_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_POLICY) begin
			policy_q <= pwdata[0];
		end
	end

	assign job = '{op: in_ch.op, job_id: in_ch.job_id, arrival: in_ch.arrival,
		burst: in_ch.burst};

	prts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_op   (in_ch.op),
		.in_ready(in_ch.ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	prts_dp #(
		.MAX_JOBS(MAX_JOBS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.job      (job),
		.policy   (policy_q),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ch.ready),
		.res      (res)
	);

	assign out_ch.valid            = out_valid;
	assign out_ch.slot_time        = res.slot_time;
	assign out_ch.idle             = res.idle;
	assign out_ch.run_id           = res.run_id;
	assign out_ch.finished         = res.finished;
	assign out_ch.turnaround       = res.turnaround;
	assign out_ch.waiting          = res.waiting;
	assign out_ch.turnaround_total = res.turnaround_total;
	assign out_ch.waiting_total    = res.waiting_total;
	assign out_ch.all_done         = res.all_done;
endmodule

[tb/preemptive_remaining_time_scheduler_tb.sv]
// Self-checking testbench for preemptive_remaining_time_scheduler: random and directed job beats
// on the input channel, tick reports checked against a scheduler predictor held in a scoreboard.
// Depends on prts_pkg, prts_in_if, prts_out_if and the scheduler RTL.
module preemptive_remaining_time_scheduler_tb
	import prts_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH = 16;
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;
	localparam int ITEM_TARGET = 1200;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int REG_UNUSED = 1;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	class sched_scoreboard;
		prts_res_t reports_due[$];
		logic [ID_W-1:0] ids[TABLE_DEPTH];
		logic [TIME_W-1:0] arrivals[TABLE_DEPTH];
		logic [TIME_W-1:0] bursts[TABLE_DEPTH];
		logic [TIME_W-1:0] rem[TABLE_DEPTH];
		bit done[TABLE_DEPTH];
		int unsigned loaded;
		int unsigned finished;
		logic [TICK_W-1:0] now;
		logic [SUM_W-1:0] sum_tat;
		logic [SUM_W-1:0] sum_wait;
		logic policy;
		int mismatches;

		function new();
			clear_table();
			policy = 1'b0;
			mismatches = 0;
		endfunction

		function void clear_table();
			foreach (done[i]) begin
				done[i] = 1'b0;
			end
			loaded = 0;
			finished = 0;
			now = '0;
			sum_tat = '0;
			sum_wait = '0;
		endfunction

		function void set_register(int unsigned index, logic [PDATA_W-1:0] data);
			if (index == REG_POLICY) begin
				policy = data[0];
			end
		endfunction

		function int unsigned pending();
			return reports_due.size();
		endfunction

		function void note_beat(prts_job_t beat);
			int best;
			prts_res_t res;
			case (beat.op)
				OP_LOAD: begin
					if (loaded < TABLE_DEPTH) begin
						ids[loaded] = beat.job_id;
						arrivals[loaded] = beat.arrival;
						bursts[loaded] = (beat.burst == '0) ? TIME_W'(1) : beat.burst;
						rem[loaded] = bursts[loaded];
						done[loaded] = 1'b0;
						loaded++;
					end
				end
				OP_CLEAR: clear_table();
				OP_TICK: begin
					best = -1;
					for (int i = 0; i < loaded; i++) begin
						if (!done[i] && TICK_W'(arrivals[i]) <= now) begin
							if (best < 0) begin
								best = i;
							end else if (policy == 1'b0 ? rem[i] < rem[best]
									: rem[i] > rem[best]) begin
								best = i;
							end
						end
					end
					res = '0;
					res.slot_time = now;
					res.idle = 1'b1;
					if (best >= 0) begin
						res.idle = 1'b0;
						res.run_id = ids[best];
						rem[best] = rem[best] - 1'b1;
						if (rem[best] == '0) begin
							res.finished = 1'b1;
							done[best] = 1'b1;
							finished++;
							res.turnaround = now + 1 - TICK_W'(arrivals[best]);
							res.waiting = res.turnaround - TICK_W'(bursts[best]);
							sum_tat = sum_tat + SUM_W'(res.turnaround);
							sum_wait = sum_wait + SUM_W'(res.waiting);
						end
					end
					res.turnaround_total = sum_tat;
					res.waiting_total = sum_wait;
					res.all_done = (finished == loaded);
					now = now + 1;
					reports_due.push_back(res);
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string field, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
				mismatches++;
			end
		endfunction

		function void check_report(prts_res_t got);
			prts_res_t want;
			if (reports_due.size() == 0) begin
				$error("tick report beat with no tick pending, slot_time 0x%0h", got.slot_time);
				mismatches++;
				return;
			end
			want = reports_due.pop_front();
			compare_field("slot_time", want.slot_time, got.slot_time);
			compare_field("idle", want.idle, got.idle);
			compare_field("run_id", want.run_id, got.run_id);
			compare_field("finished", want.finished, got.finished);
			compare_field("turnaround", want.turnaround, got.turnaround);
			compare_field("waiting", want.waiting, got.waiting);
			compare_field("turnaround_total", want.turnaround_total, got.turnaround_total);
			compare_field("waiting_total", want.waiting_total, got.waiting_total);
			compare_field("all_done", want.all_done, got.all_done);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	prts_in_if in_ch ();
	prts_out_if out_ch ();

	sched_scoreboard sb = new();

	bit tx_gaps_on;
	bit rx_gaps_on;
	bit rx_hold_req;
	int rx_gap_left;
	int items_sent;

	preemptive_remaining_time_scheduler #(
		.MAX_JOBS(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("preemptive_remaining_time_scheduler verification failed");
		$finish;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	function automatic prts_job_t job_beat(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
			logic [TIME_W-1:0] arrival, logic [TIME_W-1:0] burst);
		prts_job_t beat;
		beat.op = op;
		beat.job_id = id;
		beat.arrival = arrival;
		beat.burst = burst;
		return beat;
	endfunction

	function automatic prts_job_t random_beat(logic [OP_W-1:0] op);
		return job_beat(op, ID_W'($urandom()), TIME_W'($urandom()), TIME_W'($urandom()));
	endfunction

	function automatic prts_job_t random_job();
		prts_job_t beat;
		beat = random_beat(OP_LOAD);
		if ($urandom_range(0, 99) < 85) begin
			beat.arrival = TIME_W'(sb.now + $urandom_range(0, 10));
			beat.burst = TIME_W'($urandom_range(0, 6));
		end
		return beat;
	endfunction

	always @(posedge clk) begin
		prts_job_t beat;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			beat = job_beat(in_ch.op, in_ch.job_id, in_ch.arrival, in_ch.burst);
			sb.note_beat(beat);
		end
	end

	always @(posedge clk) begin
		prts_res_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.slot_time = out_ch.slot_time;
			got.idle = out_ch.idle;
			got.run_id = out_ch.run_id;
			got.finished = out_ch.finished;
			got.turnaround = out_ch.turnaround;
			got.waiting = out_ch.waiting;
			got.turnaround_total = out_ch.turnaround_total;
			got.waiting_total = out_ch.waiting_total;
			got.all_done = out_ch.all_done;
			sb.check_report(got);
		end
	end

	initial begin
		out_ch.ready = 1'b0;
		rx_gap_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				out_ch.ready = 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end
			if (rx_gap_left > 0) begin
				out_ch.ready = 1'b0;
				rx_gap_left--;
			end else if (rx_gaps_on && $urandom_range(0, 99) < 25) begin
				out_ch.ready = 1'b0;
				rx_gap_left = gap_len() - 1;
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	task automatic send_item(input prts_job_t beat);
		int gap;
		gap = (tx_gaps_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
		end
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.op = beat.op;
		in_ch.job_id = beat.job_id;
		in_ch.arrival = beat.arrival;
		in_ch.burst = beat.burst;
		do @(posedge clk); while (!in_ch.ready);
		if (beat.op != OP_UNUSED) begin
			items_sent++;
		end
	endtask

	task automatic quiesce();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input int unsigned index, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = PADDR_W'(4 * index);
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(index, data);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic reg_read_check(input int unsigned index);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = PADDR_W'(4 * index);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== PDATA_W'(sb.policy)) begin
			$error("policy_mode readback mismatch: expected 0x%0h, got 0x%0h",
				PDATA_W'(sb.policy), prdata);
			sb.mismatches++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic maybe_noise();
		if ($urandom_range(0, 99) < 5) begin
			send_item(random_beat(OP_UNUSED));
		end
	endtask

	task automatic run_job_set();
		int n_jobs;
		int ticks_left;
		int idle_tail;
		if ($urandom_range(0, 99) < 85) begin
			send_item(random_beat(OP_CLEAR));
		end
		n_jobs = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 20);
		repeat (n_jobs) begin
			maybe_noise();
			send_item(random_job());
		end
		ticks_left = 120;
		idle_tail = $urandom_range(0, 3);
		while (ticks_left > 0) begin
			if (sb.finished == sb.loaded) begin
				if (idle_tail == 0) begin
					break;
				end
				idle_tail--;
			end
			send_item(random_beat(OP_TICK));
			ticks_left--;
			maybe_noise();
			if ($urandom_range(0, 99) < 8) begin
				send_item(random_job());
			end
			if ($urandom_range(0, 99) < 1) begin
				send_item(random_beat(OP_CLEAR));
				break;
			end
		end
	endtask

	initial begin
		logic [PDATA_W-1:0] data;
		int phase;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_LOAD;
		in_ch.job_id = '0;
		in_ch.arrival = '0;
		in_ch.burst = '0;
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		rx_hold_req = 1'b0;
		items_sent = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		reg_read_check(REG_POLICY);
		data = $urandom();
		data[0] = 1'b0;
		reg_write(REG_POLICY, data);

		send_item(job_beat(OP_TICK, 8'h00, 16'h0000, 16'h0000));
		send_item(job_beat(OP_LOAD, 8'h00, 16'd0, 16'd3));
		send_item(job_beat(OP_LOAD, 8'hFF, 16'd0, 16'd1));
		send_item(job_beat(OP_LOAD, 8'hA5, 16'd3, 16'd0));
		send_item(job_beat(OP_LOAD, 8'h3C, 16'd2, 16'd2));
		send_item(job_beat(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF));
		repeat (9) send_item(job_beat(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF));
		send_item(job_beat(OP_CLEAR, 8'h00, 16'h0000, 16'h0000));
		send_item(job_beat(OP_LOAD, 8'h5A, 16'hFFFF, 16'hFFFF));
		send_item(job_beat(OP_TICK, 8'h00, 16'h0000, 16'h0000));
		send_item(job_beat(OP_CLEAR, 8'hFF, 16'hFFFF, 16'hFFFF));

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			quiesce();
			data = $urandom();
			data[0] = ~phase[0];
			reg_write(REG_POLICY, data);
			if ($urandom_range(0, 3) == 0) begin
				reg_write(REG_UNUSED, $urandom());
			end
			reg_read_check(REG_POLICY);
			tx_gaps_on = $urandom_range(0, 9) < 7;
			rx_gaps_on = $urandom_range(0, 9) < 7;
			if (phase == 2) begin
				tx_gaps_on = 1'b0;
				rx_hold_req = 1'b1;
			end
			repeat ($urandom_range(1, 4)) run_job_set();
			phase++;
		end

		quiesce();
		if (sb.pending() != 0) begin
			$error("%0d tick reports never arrived", sb.pending());
			sb.mismatches++;
		end
		if (sb.mismatches == 0) begin
			$display("preemptive_remaining_time_scheduler verification clean");
		end else begin
			$display("preemptive_remaining_time_scheduler verification failed");
		end
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl
rtl/prts_pkg.sv
rtl/prts_in_if.sv
rtl/prts_out_if.sv
rtl/prts_ram.sv
rtl/prts_ctrl.sv
rtl/prts_dp.sv
rtl/preemptive_remaining_time_scheduler.sv
tb/preemptive_remaining_time_scheduler_tb.sv
